/* design/eslp_pkg.sv */
`default_nettype none
package eslp_pkg;

  // result kinds
  localparam logic [2:0] K_NAME     = 3'd0;
  localparam logic [2:0] K_DATA     = 3'd1;
  localparam logic [2:0] K_RESTART  = 3'd2;
  localparam logic [2:0] K_BREAK    = 3'd3;
  localparam logic [2:0] K_DISPATCH = 3'd4;
  localparam logic [2:0] K_CLEAR    = 3'd5;

  // input actions
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_req;
  } in_item_t;

  typedef struct packed {
    logic       has;
    logic [2:0] kind;
    logic [7:0] value_byte;
  } step_res_t;

endpackage
`default_nettype wire

/* design/eslp_in_if.sv */
`default_nettype none
interface eslp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_req;

  modport source (output valid, output action, output byte_req, input ready);
  modport sink (input valid, input action, input byte_req, output ready);
endinterface
`default_nettype wire

/* design/eslp_out_if.sv */
`default_nettype none
interface eslp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value_byte;

  modport source (output valid, output kind, output value_byte, input ready);
  modport sink (input valid, input kind, input value_byte, output ready);
endinterface
`default_nettype wire

/* design/event_stream_line_parser.sv */
`default_nettype none
// channel  role    transfer payload
// -------  ------  --------------------------------------------
// stream   sink    action (1), byte_req (8): stream byte or flush
// token    source  kind (3), value_byte (8): parser result
//
// one stream transfer per cycle sustained while token takes its results;
// a byte waits in the input register, its result in the result register
// bytes that cause no result still pass through the input register
// rst is synchronous: parser state returns to line start, both stages empty
// stream.ready drops only while the input register is full and a result
// waits on token that is not taken in that cycle
module event_stream_line_parser (
  input  wire logic clk,
  input  wire logic rst,
  eslp_in_if.sink    stream,
  eslp_out_if.source token
);

  eslp_pkg::in_item_t  item;
  logic                item_valid;
  eslp_pkg::step_res_t res;
  logic                can_load;
  logic                advance;

  // the held byte moves when the result register can take its result
  assign advance = item_valid && can_load;

  // input register
  eslp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  // line state machine and result decode
  eslp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  // result register
  eslp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .advance  (advance),
    .can_load (can_load),
    .token    (token)
  );

  // marker kinds never carry a byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    token.valid && token.kind != eslp_pkg::K_NAME && token.kind != eslp_pkg::K_DATA
    |-> token.value_byte == 8'h00)
    else $error("marker result carries a nonzero byte");

  // a result produced by a moving byte is shown in the next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    advance && res.has |=> token.valid)
    else $error("result lost between step and result register");

  // an empty input register always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> stream.ready)
    else $error("input register empty but stream not ready");

  // a flush always gives a result
  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    advance && item.action == eslp_pkg::ACT_FLUSH |-> res.has)
    else $error("flush without dispatch or clear");

endmodule
`default_nettype wire

/* design/eslp_in_stage.sv */
`default_nettype none
module eslp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  eslp_in_if.sink         stream,
  input  wire logic       advance,
  output eslp_pkg::in_item_t item,
  output logic            item_valid
);

  eslp_pkg::in_item_t held;
  logic               held_valid;

  // take a new transfer when empty or when the held item moves on
  assign stream.ready = !held_valid || advance;
  assign item         = held;
  assign item_valid   = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (stream.ready) begin
      held_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      held.action   <= stream.action;
      held.byte_req <= stream.byte_req;
    end
  end

endmodule
`default_nettype wire

/* design/eslp_step.sv */
`default_nettype none
module eslp_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire eslp_pkg::in_item_t item,
  input  wire logic               advance,
  output eslp_pkg::step_res_t     res
);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [2:0] LEN_EVENT = 3'd5;
  localparam logic [2:0] LEN_DATA  = 3'd4;

  typedef enum logic [2:0] {
    PH_START,
    PH_MEVENT,
    PH_MDATA,
    PH_VEVENT,
    PH_VDATA,
    PH_SKIP
  } phase_t;

  function automatic logic [7:0] event_char(input logic [2:0] m);
    case (m)
      3'd0:    event_char = 8'h65;
      3'd1:    event_char = 8'h76;
      3'd2:    event_char = 8'h65;
      3'd3:    event_char = 8'h6E;
      3'd4:    event_char = 8'h74;
      default: event_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] data_char(input logic [2:0] m);
    case (m)
      3'd0:    data_char = 8'h64;
      3'd1:    data_char = 8'h61;
      3'd2:    data_char = 8'h74;
      3'd3:    data_char = 8'h61;
      default: data_char = 8'h00;
    endcase
  endfunction

  phase_t     line_phase, line_phase_next;
  logic [2:0] field_match, field_match_next;
  logic       first_value_byte, first_value_byte_next;
  logic       carriage_return_pending, carriage_return_pending_next;
  logic       event_has_data, event_has_data_next;

  logic [7:0] c;
  logic       is_event;
  logic [2:0] len;
  logic [7:0] want;

  assign c        = item.byte_req;
  assign is_event = (line_phase == PH_MEVENT);
  assign len      = is_event ? LEN_EVENT : LEN_DATA;
  assign want     = is_event ? event_char(field_match) : data_char(field_match);

  always_comb begin
    line_phase_next              = line_phase;
    field_match_next             = field_match;
    first_value_byte_next        = first_value_byte;
    carriage_return_pending_next = carriage_return_pending;
    event_has_data_next          = event_has_data;
    res                          = '0;

    if (item.action == eslp_pkg::ACT_FLUSH) begin
      // end of stream: close the event, back to reset state
      res.has                      = 1'b1;
      res.kind = event_has_data ? eslp_pkg::K_DISPATCH : eslp_pkg::K_CLEAR;
      line_phase_next              = PH_START;
      field_match_next             = 3'd0;
      first_value_byte_next        = 1'b0;
      carriage_return_pending_next = 1'b0;
      event_has_data_next          = 1'b0;
    end else if (carriage_return_pending && c == CH_LF) begin
      // lf of a split crlf
      carriage_return_pending_next = 1'b0;
    end else if (c == CH_LF || c == CH_CR) begin
      line_phase_next              = PH_START;
      field_match_next             = 3'd0;
      first_value_byte_next        = 1'b0;
      carriage_return_pending_next = (c == CH_CR);
      if (line_phase == PH_START) begin
        res.has             = 1'b1;
        res.kind = event_has_data ? eslp_pkg::K_DISPATCH : eslp_pkg::K_CLEAR;
        event_has_data_next = 1'b0;
      end
    end else begin
      carriage_return_pending_next = 1'b0;
      case (line_phase)
        PH_START: begin
          if (c == CH_E) begin
            line_phase_next  = PH_MEVENT;
            field_match_next = 3'd1;
          end else if (c == CH_D) begin
            line_phase_next  = PH_MDATA;
            field_match_next = 3'd1;
          end else begin
            line_phase_next = PH_SKIP;
          end
        end
        PH_MEVENT, PH_MDATA: begin
          if (c == CH_COLON) begin
            if (field_match != len) begin
              line_phase_next = PH_SKIP;
            end else if (is_event) begin
              first_value_byte_next = 1'b1;
              line_phase_next       = PH_VEVENT;
              res.has               = 1'b1;
              res.kind              = eslp_pkg::K_RESTART;
            end else begin
              first_value_byte_next = 1'b1;
              line_phase_next       = PH_VDATA;
              event_has_data_next   = 1'b1;
              if (event_has_data) begin
                res.has  = 1'b1;
                res.kind = eslp_pkg::K_BREAK;
              end
            end
          end else if (field_match < len && c == want) begin
            field_match_next = field_match + 3'd1;
          end else begin
            line_phase_next = PH_SKIP;
          end
        end
        PH_VEVENT, PH_VDATA: begin
          first_value_byte_next = 1'b0;
          if (!(first_value_byte && c == CH_SPACE)) begin
            res.has        = 1'b1;
            res.kind       = (line_phase == PH_VEVENT) ? eslp_pkg::K_NAME : eslp_pkg::K_DATA;
            res.value_byte = c;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase              <= PH_START;
      field_match             <= 3'd0;
      first_value_byte        <= 1'b0;
      carriage_return_pending <= 1'b0;
      event_has_data          <= 1'b0;
    end else if (advance) begin
      line_phase              <= line_phase_next;
      field_match             <= field_match_next;
      first_value_byte        <= first_value_byte_next;
      carriage_return_pending <= carriage_return_pending_next;
      event_has_data          <= event_has_data_next;
    end
  end

endmodule
`default_nettype wire

/* design/eslp_out_stage.sv */
`default_nettype none
module eslp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire eslp_pkg::step_res_t res,
  input  wire logic                advance,
  output logic                     can_load,
  eslp_out_if.source               token
);

  logic       held_valid;
  logic [2:0] kind;
  logic [7:0] value_byte;
  logic       load;

  assign can_load         = !held_valid || token.ready;
  assign load             = advance && res.has;
  assign token.valid      = held_valid;
  assign token.kind       = kind;
  assign token.value_byte = value_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (token.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= res.kind;
      value_byte <= res.value_byte;
    end
  end

endmodule
`default_nettype wire

/* tb/eslp_token_predictor.sv */
`timescale 1ns / 100ps
module eslp_token_predictor (
  input  logic        clk,
  input  logic        rst,
  eslp_in_if          stream,
  eslp_out_if         token,
  output int unsigned error_count,
  output int unsigned pending_count
);

  localparam logic [7:0]  LF          = 8'h0A;
  localparam logic [7:0]  CR          = 8'h0D;
  localparam logic [7:0]  COLON       = 8'h3A;
  localparam logic [7:0]  SP          = 8'h20;
  localparam logic [39:0] EVENT_WORD  = "event";
  localparam logic [31:0] DATA_WORD   = "data";

  typedef enum logic [2:0] {
    LN_START, LN_MATCH_EVENT, LN_MATCH_DATA, LN_EVENT_VALUE, LN_DATA_VALUE, LN_SKIP
  } line_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value_byte;
  } token_t;

  line_state_t line_state;
  logic [2:0]  name_matched;
  logic        value_first;
  logic        cr_pending;
  logic        event_has_data;
  token_t      predicted_tokens[$];

  function automatic void clear_line_state();
    line_state     = LN_START;
    name_matched   = 3'd0;
    value_first    = 1'b0;
    cr_pending     = 1'b0;
    event_has_data = 1'b0;
  endfunction

  // one parser step; got is high when the step yields a token
  task automatic parse_item(input logic act, input logic [7:0] c, output logic got,
                            output token_t tok);
    logic       blank;
    logic       is_event;
    logic [2:0] word_len;
    logic       char_ok;
    got = 1'b0;
    tok = '{eslp_pkg::K_NAME, 8'h00};
    if (act == eslp_pkg::ACT_FLUSH) begin
      got = 1'b1;
      tok.kind = event_has_data ? eslp_pkg::K_DISPATCH : eslp_pkg::K_CLEAR;
      clear_line_state();
    end else if (cr_pending && c == LF) begin
      cr_pending = 1'b0;
    end else begin
      cr_pending = 1'b0;
      if (c == LF || c == CR) begin
        blank        = (line_state == LN_START);
        line_state   = LN_START;
        name_matched = 3'd0;
        value_first  = 1'b0;
        cr_pending   = (c == CR);
        if (blank) begin
          got = 1'b1;
          tok.kind = event_has_data ? eslp_pkg::K_DISPATCH : eslp_pkg::K_CLEAR;
          event_has_data = 1'b0;
        end
      end else begin
        case (line_state)
          LN_START: begin
            name_matched = 3'd1;
            if (c == "e") line_state = LN_MATCH_EVENT;
            else if (c == "d") line_state = LN_MATCH_DATA;
            else line_state = LN_SKIP;
          end
          LN_MATCH_EVENT, LN_MATCH_DATA: begin
            is_event = (line_state == LN_MATCH_EVENT);
            word_len = is_event ? 3'd5 : 3'd4;
            if (c == COLON) begin
              if (name_matched != word_len) begin
                line_state = LN_SKIP;
              end else begin
                value_first = 1'b1;
                if (is_event) begin
                  line_state = LN_EVENT_VALUE;
                  got = 1'b1;
                  tok.kind = eslp_pkg::K_RESTART;
                end else begin
                  line_state = LN_DATA_VALUE;
                  if (event_has_data) begin
                    got = 1'b1;
                    tok.kind = eslp_pkg::K_BREAK;
                  end
                  event_has_data = 1'b1;
                end
              end
            end else begin
              char_ok = 1'b0;
              if (name_matched < word_len) begin
                char_ok = is_event ? (c == EVENT_WORD[8*(4-name_matched) +: 8])
                                   : (c == DATA_WORD[8*(3-name_matched) +: 8]);
              end
              if (char_ok) name_matched = name_matched + 3'd1;
              else line_state = LN_SKIP;
            end
          end
          LN_EVENT_VALUE, LN_DATA_VALUE: begin
            if (!(value_first && c == SP)) begin
              got = 1'b1;
              tok.kind = (line_state == LN_EVENT_VALUE) ? eslp_pkg::K_NAME : eslp_pkg::K_DATA;
              tok.value_byte = c;
            end
            value_first = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    logic   got;
    token_t tok;
    token_t want;
    if (rst) begin
      clear_line_state();
      predicted_tokens.delete();
    end else begin
      // result side first: nothing taken this edge can show up yet
      if (token.valid && token.ready) begin
        if (predicted_tokens.size() == 0) begin
          error_count++;
          $display("%0t: unexpected token, expected none, actual kind %0d byte %02h",
                   $time, token.kind, token.value_byte);
        end else begin
          want = predicted_tokens.pop_front();
          if (token.kind !== want.kind) begin
            error_count++;
            $display("%0t: token kind expected %0d actual %0d",
                     $time, want.kind, token.kind);
          end
          if (token.value_byte !== want.value_byte) begin
            error_count++;
            $display("%0t: token byte expected %02h actual %02h",
                     $time, want.value_byte, token.value_byte);
          end
        end
      end
      if (stream.valid && stream.ready) begin
        parse_item(stream.action, stream.byte_req, got, tok);
        if (got) predicted_tokens.insert(predicted_tokens.size(), tok);
      end
    end
    pending_count = predicted_tokens.size();
  end

endmodule

/* tb/event_stream_line_parser_test.sv */
`timescale 1ns / 100ps
module event_stream_line_parser_test;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT  = 5000;
  // result register latency plus margin, waited out after the last token
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [7:0] LF    = 8'h0A;
  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] COLON = 8'h3A;
  localparam logic [7:0] SP    = 8'h20;

  logic               clk;
  logic               rst;
  int unsigned        error_count;
  int unsigned        pending_count;
  int unsigned        quiet_cycles;
  int unsigned        send_idle_pct;
  int unsigned        stall_pct;
  eslp_pkg::in_item_t line_items[$];

  eslp_in_if  stream_if ();
  eslp_out_if token_if ();

  event_stream_line_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .token  (token_if)
  );

  // watches both channels, predicts tokens and counts mismatches
  eslp_token_predictor predictor (
    .clk           (clk),
    .rst           (rst),
    .stream        (stream_if),
    .token         (token_if),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // token side back-pressure, one fresh draw per cycle
  always @(posedge clk) begin
    token_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((stream_if.valid && stream_if.ready) ||
                 (token_if.valid && token_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one stream transfer; returns at the edge where it is taken
  // ready is looked at on the falling edge, where it is settled
  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid    <= 1'b1;
    stream_if.action   <= act;
    stream_if.byte_req <= b;
    do @(negedge clk); while (!stream_if.ready);
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(eslp_pkg::ACT_BYTE, s[i]);
  endtask

  // append one item to the line being built
  function automatic void add_item(input logic act, input logic [7:0] b);
    eslp_pkg::in_item_t it;
    it.action   = act;
    it.byte_req = b;
    line_items.insert(line_items.size(), it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(eslp_pkg::ACT_BYTE, s[i]);
  endfunction

  // field value: optional leading space, then up to six bytes biased toward
  // spaces, colons and the letter e; line breaks inside are mostly avoided
  function automatic void add_value();
    int unsigned n;
    logic [7:0]  b;
    if ($urandom_range(1)) add_item(eslp_pkg::ACT_BYTE, SP);
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: b = SP;
        1: b = COLON;
        2: b = "e";
        default: b = 8'($urandom_range(255));
      endcase
      if ((b == LF || b == CR) && $urandom_range(9) != 0) b = b ^ 8'h40;
      add_item(eslp_pkg::ACT_BYTE, b);
    end
  endfunction

  // line ending: LF, lone CR, CR then LF as two transfers, or a flush mid-line
  function automatic void add_end();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) begin
      add_item(eslp_pkg::ACT_FLUSH, 8'($urandom_range(255)));
    end else if (r < 9) begin
      add_item(eslp_pkg::ACT_BYTE, LF);
    end else begin
      add_item(eslp_pkg::ACT_BYTE, CR);
      if (r >= 15) add_item(eslp_pkg::ACT_BYTE, LF);
    end
  endfunction

  // mostly well-formed lines with random content, plus noise and near misses
  task automatic send_random_line(inout int unsigned sent);
    int unsigned pick;
    string       w;
    line_items.delete();
    if ($urandom_range(1)) w = "event";
    else w = "data";
    pick = $urandom_range(99);
    if (pick < 4) begin
      add_item(eslp_pkg::ACT_FLUSH, 8'($urandom_range(255)));
    end else if (pick < 6) begin
      // stray byte, may start or break a line
      add_item(eslp_pkg::ACT_BYTE, 8'($urandom_range(255)));
    end else if (pick < 60) begin
      if (pick < 42) add_text("data");
      else add_text("event");
      add_text(":");
      add_value();
      add_end();
    end else if (pick < 75) begin
      // blank line
      add_end();
    end else if (pick < 82) begin
      // comment
      add_text(":");
      add_value();
      add_end();
    end else if (pick < 90) begin
      // fields the parser ignores
      case ($urandom_range(3))
        0: add_text("id");
        1: add_text("retry");
        2: add_text("x");
        default: add_text("Data");
      endcase
      add_text(":");
      add_value();
      add_end();
    end else begin
      // near misses on the field name
      case ($urandom_range(3))
        0: begin
          add_text(w.substr(0, $urandom_range(w.len() - 2)));
          add_text(":");
        end
        1: begin
          add_text(w);
          add_item(eslp_pkg::ACT_BYTE, 8'("a" + $urandom_range(25)));
          add_text(":");
        end
        2: add_text(w);
        default: begin
          add_text(w);
          line_items[$urandom_range(w.len() - 1)].byte_req ^= 8'h20;
          add_text(":");
        end
      endcase
      add_value();
      add_end();
    end
    foreach (line_items[i]) send_item(line_items[i].action, line_items[i].byte_req);
    sent += line_items.size();
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned sent;
    send_idle_pct = idle;
    stall_pct     = stall;
    sent = 0;
    while (sent < PHASE_ITEMS) send_random_line(sent);
  endtask

  initial begin
    stream_if.valid    <= 1'b0;
    stream_if.action   <= eslp_pkg::ACT_BYTE;
    stream_if.byte_req <= 8'h00;
    rst                <= 1'b1;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first data line: leading space dropped, zero byte passes, CR then LF absorbed
    send_text("data: ");
    send_item(eslp_pkg::ACT_BYTE, 8'h00);
    send_item(eslp_pkg::ACT_BYTE, CR);
    send_item(eslp_pkg::ACT_BYTE, LF);
    // second data line gives a line break, top byte value
    send_text("data:");
    send_item(eslp_pkg::ACT_BYTE, 8'hFF);
    send_item(eslp_pkg::ACT_BYTE, LF);
    // blank line with data pending dispatches
    send_item(eslp_pkg::ACT_BYTE, CR);
    // event name restart, only the first space dropped, then flush with no data
    send_text("event:  ");
    send_item(eslp_pkg::ACT_FLUSH, 8'hFF);

    // random traffic under each flow-control pattern
    run_phase(0, 0);
    run_phase(86, 0);
    run_phase(0, 86);
    run_phase(16, 16);
    stream_if.valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
